### design/mnpr_pkg.sv
// mnpr_pkg: shared types and constants of the mesh node prolongation/restriction unit
// no dependencies; used by the channel interfaces, the index reducer and the top level
package mnpr_pkg;

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 12;
  localparam int WORD_W = 32;

  localparam int DEF_VECTOR_DEPTH = 4096;
  localparam int DEF_VALUE_WIDTH  = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE    = 2'd0,
    REQ_READ     = 2'd1,
    REQ_PROLONG  = 2'd2,
    REQ_RESTRICT = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDX,
    S_WR,
    S_RD0,
    S_RD1,
    S_P0,
    S_P1,
    S_P2,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_R5,
    S_FIN
  } state_t;

  // load strobes for the two stages of the index reducer
  typedef struct packed {
    logic capture;
    logic finish;
  } idx_ctl_t;

endpackage

### design/mnpr_if.sv
// mnpr_req_if / mnpr_rsp_if: valid/ready channels for requests and results
// depends on mnpr_pkg for the field widths
interface mnpr_req_if import mnpr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [IDX_W-1:0]         node_index;
  logic [IDX_W-1:0]         parent_a;
  logic [IDX_W-1:0]         parent_b;
  logic signed [WORD_W-1:0] write_value;

  modport source (output valid, req_type, node_index, parent_a, parent_b, write_value,
                  input ready);
  modport sink (input valid, req_type, node_index, parent_a, parent_b, write_value,
                output ready);
endinterface

interface mnpr_rsp_if import mnpr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic                     status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

### design/mesh_node_prolong_restrict_unit.sv
// mesh_node_prolong_restrict_unit: vector store with write, read, prolongate and restrict
// depends on mnpr_pkg, mnpr_if, mnpr_ram, mnpr_alu and mnpr_idx_mod
//
// Requests arrive on req (valid/ready) and each gives one result on rsp (valid/ready).
// A request is taken only while the sequencer is idle; it then owns the single
// write port and registered read port of the vector memory until it finishes.
// Indexes are reduced modulo VECTOR_DEPTH first: captured at acceptance, finished in state S_IDX.
// The time from one accepted request to the next is set by the memory accesses in turn:
// restrict reads three entries and writes three through one port pair, and all sums
// go through one shared adder.
// The result is held in an output register, so rsp.valid rises in the same cycle
// that req.ready returns, and the next request can be taken in that cycle. If rsp stalls, the next
// request is still taken and worked; it then waits at the end until the output register frees.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output
// register; memory contents are not cleared and are undefined until written.
module mesh_node_prolong_restrict_unit import mnpr_pkg::*; #(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH,
  parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  mnpr_req_if.sink   req,
  mnpr_rsp_if.source rsp
);

  localparam int W  = VALUE_WIDTH;
  localparam int IW = $clog2(VECTOR_DEPTH);
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (W-1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
  localparam logic signed [63:0] OMAX = 64'sd2147483647;
  localparam logic signed [63:0] OMIN = -OMAX - 64'sd1;

  // fit a request word into the entry width; top bit is the clamp flag
  function automatic logic [W:0] fit_in(input logic signed [WORD_W-1:0] v);
    logic signed [63:0] wide;
    logic [W:0]         res;
    wide = 64'(v);
    if (wide > VMAX) begin
      res = {1'b1, VMAX[W-1:0]};
    end else if (wide < VMIN) begin
      res = {1'b1, VMIN[W-1:0]};
    end else begin
      res = {1'b0, wide[W-1:0]};
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] fit_out(input logic signed [W-1:0] v);
    logic signed [63:0]  wide;
    logic [WORD_W-1:0]   res;
    wide = 64'(v);
    if (wide > OMAX) begin
      res = OMAX[WORD_W-1:0];
    end else if (wide < OMIN) begin
      res = OMIN[WORD_W-1:0];
    end else begin
      res = wide[WORD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [W-1:0] asr1(input logic [W-1:0] v);
    return {v[W-1], v[W-1:1]};
  endfunction

  state_t state, state_next;

  req_type_t                req_q;
  logic signed [WORD_W-1:0] wv_q;
  logic [W-1:0]             opa;
  logic [W-1:0]             half;
  logic [W-1:0]             result_q;
  logic                     flag;

  logic                     out_valid;
  logic [WORD_W-1:0]        out_value;
  logic                     out_status;
  logic                     out_load;

  logic                     req_take;
  idx_ctl_t                 idx_ctl;
  logic [IW-1:0]            n_idx, pa_idx, pb_idx;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr, ram_raddr;
  logic [W-1:0]             ram_wdata, ram_rdata;

  logic signed [W-1:0]      alu_x, alu_y, alu_sum;
  logic                     alu_cin, alu_ovf;
  logic [W:0]               wr_fit;

  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;

  assign idx_ctl.capture = req_take;
  assign idx_ctl.finish  = (state == S_IDX);

  assign wr_fit = fit_in(wv_q);

  mnpr_idx_mod #(.DEPTH(VECTOR_DEPTH)) u_mod_n (
    .clk(clk), .ctl(idx_ctl), .raw(req.node_index), .idx(n_idx)
  );
  mnpr_idx_mod #(.DEPTH(VECTOR_DEPTH)) u_mod_a (
    .clk(clk), .ctl(idx_ctl), .raw(req.parent_a), .idx(pa_idx)
  );
  mnpr_idx_mod #(.DEPTH(VECTOR_DEPTH)) u_mod_b (
    .clk(clk), .ctl(idx_ctl), .raw(req.parent_b), .idx(pb_idx)
  );

  mnpr_ram #(.WIDTH(W), .DEPTH(VECTOR_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  mnpr_alu #(.WIDTH(W)) u_alu (
    .x(alu_x), .y(alu_y), .cin(alu_cin), .sum(alu_sum), .ovf(alu_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = n_idx;
    ram_wdata  = '0;
    ram_raddr  = n_idx;
    alu_x      = ram_rdata;
    alu_y      = half;
    alu_cin    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_take) state_next = S_IDX;
      end
      S_IDX: begin
        unique case (req_q)
          REQ_WRITE:    state_next = S_WR;
          REQ_READ:     state_next = S_RD0;
          REQ_PROLONG:  state_next = S_P0;
          REQ_RESTRICT: state_next = S_R0;
          default:      state_next = S_WR;
        endcase
      end
      S_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = wr_fit[W-1:0];
        state_next = S_FIN;
      end
      S_RD0: state_next = S_RD1;
      S_RD1: state_next = S_FIN;
      S_P0: begin
        ram_raddr  = pa_idx;
        state_next = S_P1;
      end
      S_P1: begin
        ram_raddr  = pb_idx;
        state_next = S_P2;
      end
      S_P2: begin
        // half sum as (a>>1)+(b>>1)+(a&b&1), never out of range
        alu_x      = asr1(opa);
        alu_y      = asr1(ram_rdata);
        alu_cin    = opa[0] & ram_rdata[0];
        ram_we     = 1'b1;
        ram_wdata  = alu_sum;
        state_next = S_FIN;
      end
      S_R0: state_next = S_R1;
      S_R1: begin
        ram_raddr  = pa_idx;
        state_next = S_R2;
      end
      S_R2: begin
        ram_we     = 1'b1;
        ram_waddr  = pa_idx;
        ram_wdata  = alu_sum;
        state_next = S_R3;
      end
      S_R3: begin
        // read after the first parent write so an equal index sees the update
        ram_raddr  = pb_idx;
        state_next = S_R4;
      end
      S_R4: begin
        ram_we     = 1'b1;
        ram_waddr  = pb_idx;
        ram_wdata  = alu_sum;
        state_next = S_R5;
      end
      S_R5: begin
        ram_we     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          req_q    <= req_type_t'(req.req_type);
          wv_q     <= req.write_value;
          result_q <= '0;
          flag     <= 1'b0;
        end
      end
      S_WR:        flag     <= wr_fit[W];
      S_RD1:       result_q <= ram_rdata;
      S_P1:        opa      <= ram_rdata;
      S_P2:        result_q <= alu_sum;
      S_R1:        half     <= asr1(ram_rdata);
      S_R2, S_R4:  flag     <= flag | alu_ovf;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value  <= fit_out(result_q);
      out_status <= flag;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("memory written while idle");

  a_prolong_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_P2 |-> !alu_ovf)
    else $error("prolongate half sum overflowed");

  a_flag_kind: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> !(flag && (req_q == REQ_READ || req_q == REQ_PROLONG)))
    else $error("status set for read or prolongate");

  a_fin_to_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("finished request not loaded to output");
`endif

endmodule

### design/mnpr_ram.sv
// mnpr_ram: generic single write port, single read port RAM with registered read
// no dependencies
module mnpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mnpr_alu.sv
// mnpr_alu: shared saturating adder with carry in, used for prolongate and restrict sums
// no dependencies
module mnpr_alu #(
  parameter int WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] x,
  input  logic signed [WIDTH-1:0] y,
  input  logic                    cin,
  output logic signed [WIDTH-1:0] sum,
  output logic                    ovf
);

  logic signed [WIDTH:0] raw;

  always_comb begin
    raw = (WIDTH+1)'(x) + (WIDTH+1)'(y) + (WIDTH+1)'({1'b0, cin});
    ovf = raw[WIDTH] != raw[WIDTH-1];
    if (ovf) begin
      // clamp toward the sign of the true sum
      sum = raw[WIDTH] ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
    end else begin
      sum = raw[WIDTH-1:0];
    end
  end

endmodule

### design/mnpr_idx_mod.sv
// mnpr_idx_mod: two-stage reduction of a request index modulo the vector depth
// depends on mnpr_pkg; quotient by reciprocal multiply, then one correcting subtract
module mnpr_idx_mod import mnpr_pkg::*; #(
  parameter int DEPTH = DEF_VECTOR_DEPTH
) (
  input  logic                     clk,
  input  idx_ctl_t                 ctl,
  input  logic [IDX_W-1:0]         raw,
  output logic [$clog2(DEPTH)-1:0] idx
);

  localparam int SHIFT = 24;
  localparam int PW    = IDX_W + SHIFT + 1;
  localparam logic [SHIFT:0] RECIP = (SHIFT+1)'((64'd1 << SHIFT) / DEPTH);
  localparam logic [31:0]    DEP   = 32'(DEPTH);

  logic [PW-1:0]       prod;
  logic [IDX_W-1:0]    raw_q;
  logic [IDX_W-1:0]    quo_q;
  logic [IDX_W+31:0]   qd;
  logic [IDX_W:0]      rem0;
  logic [31:0]         rem;

  assign prod = PW'(raw) * PW'(RECIP);

  // estimate is exact or one low, so the remainder stays below twice the depth
  always_comb begin
    qd   = (IDX_W+32)'(quo_q) * (IDX_W+32)'(DEP);
    rem0 = {1'b0, raw_q} - qd[IDX_W:0];
    rem  = (32'(rem0) >= DEP) ? 32'(rem0) - DEP : 32'(rem0);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      raw_q <= raw;
      quo_q <= prod[IDX_W+SHIFT-1:SHIFT];
    end
    if (ctl.finish) begin
      idx <= rem[$clog2(DEPTH)-1:0];
    end
  end

endmodule
